// ===== hw/rtl/fde_pkg.sv =====
// ----------------------------------------------------------------------------
// fde_pkg: shared types, codes and float helpers for the field delta encoder
// Item layouts between front, queue and back, and IEEE single helpers.
// ----------------------------------------------------------------------------
package fde_pkg;

    localparam int QUEUE_DEPTH  = 2;
    localparam int SCALE_STAGES = 7;
    localparam int FIELD_BITS   = 32;

    localparam logic [2:0] KIND_UNSIGNED = 3'd1;
    localparam logic [2:0] KIND_SIGNED   = 3'd2;
    localparam logic [2:0] KIND_RANGED   = 3'd3;
    localparam logic [2:0] KIND_STRICT   = 3'd4;

    localparam logic REG_XOR  = 1'b0;
    localparam logic REG_ZERO = 1'b1;

    localparam logic [31:0] QNAN      = 32'h7FC0_0000;
    localparam logic [31:0] NEG_2P31  = 32'hCF00_0000;

    typedef struct packed {
        logic [2:0]  pre_bits;
        logic [1:0]  pre_len;
        logic [31:0] body;
        logic [5:0]  body_len;
        logic        strict;
        logic        xor_en;
    } fde_meta_t;

    typedef struct packed {
        fde_meta_t   meta;
        logic [31:0] base;
        logic [31:0] target;
        logic [31:0] scale;
        logic [31:0] offset;
    } fde_item_t;

    function automatic logic fde_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    // a < b in float order, false on NaN
    function automatic logic fde_lt(input logic [31:0] a, input logic [31:0] b);
        logic r;
        if (fde_is_nan(a) || fde_is_nan(b))
            r = 1'b0;
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            r = 1'b0;
        else if (a[31] != b[31])
            r = a[31];
        else if (!a[31])
            r = a[30:0] < b[30:0];
        else
            r = a[30:0] > b[30:0];
        return r;
    endfunction

    // sig = {24-bit significand with leading one, guard, sticky}; round to nearest even
    function automatic logic [31:0] fde_round_pack(input logic sign,
                                                   input logic signed [10:0] e,
                                                   input logic [25:0] sig);
        logic signed [10:0] dd;
        logic signed [10:0] e2;
        logic [4:0]  d;
        logic [25:0] sh;
        logic        lost;
        logic [23:0] m;
        logic        g;
        logic        s;
        logic        inc;
        logic [24:0] mr;
        logic [31:0] r;
        if (e < 11'sd1)
        begin
            dd   = 11'sd1 - e;
            d    = (dd > 11'sd27) ? 5'd27 : dd[4:0];
            sh   = sig >> d;
            lost = |(sig & ~({26{1'b1}} << d));
            m    = sh[25:2];
            g    = sh[1];
            s    = sh[0] | lost;
            inc  = g & (s | m[0]);
            mr   = {1'b0, m} + {24'd0, inc};
            e2   = e;
            // carry into the hidden bit lands on the smallest normal
            r    = {sign, 7'd0, mr[23], mr[22:0]};
        end
        else
        begin
            dd   = 11'sd0;
            d    = 5'd0;
            sh   = sig;
            lost = 1'b0;
            m    = sig[25:2];
            g    = sig[1];
            s    = sig[0];
            inc  = g & (s | m[0]);
            mr   = {1'b0, m} + {24'd0, inc};
            e2   = mr[24] ? (e + 11'sd1) : e;
            if (e2 > 11'sd254)
                r = {sign, 8'hFF, 23'd0};
            else
                r = {sign, e2[7:0], (mr[24] ? 23'd0 : mr[22:0])};
        end
        return r;
    endfunction

    // truncate toward zero with saturation to unsigned 32 bits
    function automatic logic [31:0] fde_to_uint(input logic [31:0] f);
        logic [7:0]  e;
        logic [31:0] m;
        logic [31:0] r;
        e = f[30:23];
        m = {8'd0, 1'b1, f[22:0]};
        if (fde_is_nan(f) || f[31])
            r = 32'd0;
        else if (e >= 8'd159)
            r = 32'hFFFF_FFFF;
        else if (e < 8'd127)
            r = 32'd0;
        else if (e >= 8'd150)
            r = m << (e - 8'd150);
        else
            r = m >> (8'd150 - e);
        return r;
    endfunction

endpackage

// ===== hw/rtl/fde_front.sv =====
// ----------------------------------------------------------------------------
// fde_front: input stage
// Accepts items, decides prefix and body of each code and registers the result.
// ----------------------------------------------------------------------------
module fde_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [175:0]        s_tdata,
    input  logic                xor_en,
    input  logic                zero_en,
    input  logic                q_full,
    output logic                item_valid,
    output fde_pkg::fde_item_t  item
);

    logic               valid_reg;
    logic               valid_next;
    fde_pkg::fde_item_t item_reg;
    fde_pkg::fde_item_t item_next;

    logic [31:0] base;
    logic [31:0] tgt;
    logic [2:0]  kind;
    logic [5:0]  wid;
    logic [31:0] lim;
    logic [5:0]  wclamp;
    logic [31:0] xval;
    logic [7:0]  e;
    logic [31:0] m32;
    logic [7:0]  sh;
    logic [31:0] mag;
    logic        frac_ok;
    logic        is_int;
    logic [31:0] ival;
    logic        in_rng;
    logic        short_ok;

    assign s_tready   = !valid_reg || !q_full;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        base   = s_tdata[31:0];
        tgt    = s_tdata[63:32];
        kind   = s_tdata[66:64];
        wid    = s_tdata[72:67];
        lim    = s_tdata[104:73];
        wclamp = (wid > 6'(fde_pkg::FIELD_BITS)) ? 6'(fde_pkg::FIELD_BITS) : wid;
        xval   = xor_en ? (base ^ tgt) : tgt;

        // integer value of the target float
        e   = tgt[30:23];
        m32 = {8'd0, 1'b1, tgt[22:0]};
        sh  = 8'd150 - e;
        if (e >= 8'd150)
        begin
            mag     = m32 << (e - 8'd150);
            frac_ok = 1'b1;
        end
        else
        begin
            mag     = m32 >> sh;
            frac_ok = ((mag << sh) == m32);
        end
        is_int   = (e < 8'd127) ? (tgt[30:0] == 31'd0) : frac_ok;
        ival     = (e < 8'd127) ? 32'd0 : (tgt[31] ? (32'd0 - mag) : mag);
        in_rng   = (e < 8'd158) || (tgt == fde_pkg::NEG_2P31);
        short_ok = in_rng && is_int && !fde_pkg::fde_lt(lim, tgt)
                   && !fde_pkg::fde_lt(tgt, {~lim[31], lim[30:0]});

        item_next                 = '0;
        item_next.base            = base;
        item_next.target          = tgt;
        item_next.scale           = s_tdata[136:105];
        item_next.offset          = s_tdata[168:137];
        item_next.meta.xor_en     = xor_en;
        if (base == tgt)
        begin
            item_next.meta.pre_bits = 3'b001;
            item_next.meta.pre_len  = 2'd1;
        end
        else if (zero_en && (tgt == 32'd0))
        begin
            item_next.meta.pre_bits = 3'b001;
            item_next.meta.pre_len  = 2'd2;
        end
        else
        begin
            item_next.meta.pre_len = 2'd1 + {1'b0, zero_en};
            case (kind) inside
                fde_pkg::KIND_UNSIGNED, fde_pkg::KIND_SIGNED:
                begin
                    item_next.meta.body     = xval;
                    item_next.meta.body_len = wclamp;
                end
                fde_pkg::KIND_RANGED:
                begin
                    item_next.meta.pre_len = item_next.meta.pre_len + 2'd1;
                    if (short_ok)
                    begin
                        item_next.meta.body     = ival;
                        item_next.meta.body_len = wclamp;
                    end
                    else
                    begin
                        item_next.meta.pre_bits = 3'b001;
                        item_next.meta.body     = xval;
                        item_next.meta.body_len = 6'd32;
                    end
                end
                fde_pkg::KIND_STRICT:
                begin
                    item_next.meta.strict   = 1'b1;
                    item_next.meta.body_len = wclamp;
                end
                default:
                begin
                    item_next.meta.body_len = 6'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
            valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= item_next;
    end

endmodule

// ===== hw/rtl/fde_queue.sv =====
// ----------------------------------------------------------------------------
// fde_queue: item queue between front and back
// Small circular buffer; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module fde_queue
#(
    parameter int DEPTH = fde_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fde_pkg::fde_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output fde_pkg::fde_item_t  head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fde_pkg::fde_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/fde_scale.sv =====
// ----------------------------------------------------------------------------
// fde_scale: float scale, offset and truncate pipeline
// Computes trunc_sat(round(round(x*m) + c)) over seven register stages.
// ----------------------------------------------------------------------------
module fde_scale
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x,
    input  logic [31:0] scale,
    input  logic [31:0] offset,
    output logic [31:0] result
);

    // stage 1: multiply
    logic [47:0]        s1_p_reg;
    logic signed [10:0] s1_e_reg;
    logic               s1_sign_reg;
    logic               s1_spec_reg;
    logic [31:0]        s1_specv_reg;
    logic [31:0]        c1_reg;
    // stage 2: normalize product
    logic [25:0]        s2_sig_reg;
    logic signed [10:0] s2_e_reg;
    logic               s2_sign_reg;
    logic               s2_spec_reg;
    logic [31:0]        s2_specv_reg;
    logic [31:0]        c2_reg;
    // stage 3: round product
    logic [31:0]        s3_f_reg;
    logic [31:0]        c3_reg;
    // stage 4: align and add
    logic [27:0]        s4_sum_reg;
    logic [7:0]         s4_e_reg;
    logic               s4_sign_reg;
    logic               s4_spec_reg;
    logic [31:0]        s4_specv_reg;
    // stage 5: normalize sum
    logic [25:0]        s5_sig_reg;
    logic signed [10:0] s5_e_reg;
    logic               s5_sign_reg;
    logic               s5_spec_reg;
    logic [31:0]        s5_specv_reg;
    // stage 6 and 7
    logic [31:0]        s6_f_reg;
    logic [31:0]        s7_u_reg;

    logic [7:0]  ex;
    logic [7:0]  em;
    logic [23:0] mx;
    logic [23:0] mm;
    logic        nan_x;
    logic        nan_m;
    logic        inf_x;
    logic        inf_m;
    logic        zero_x;
    logic        zero_m;
    logic        psign;
    logic        spec1;
    logic [31:0] specv1;

    logic [5:0]  l1;
    logic [47:0] n1;

    logic [31:0] big;
    logic [31:0] lit;
    logic [7:0]  eb;
    logic [7:0]  el;
    logic [23:0] mb;
    logic [23:0] ml;
    logic [7:0]  dexp;
    logic [4:0]  dcl;
    logic [26:0] lx;
    logic [26:0] lsh;
    logic        lost;
    logic [26:0] lal;
    logic        sub;
    logic [27:0] sum;
    logic        spec4;
    logic [31:0] specv4;

    logic [4:0]  l5;
    logic [27:0] n5;

    assign result = s7_u_reg;

    always_comb
    begin
        ex     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        em     = (scale[30:23] == 8'd0) ? 8'd1 : scale[30:23];
        mx     = {(x[30:23] != 8'd0), x[22:0]};
        mm     = {(scale[30:23] != 8'd0), scale[22:0]};
        nan_x  = fde_pkg::fde_is_nan(x);
        nan_m  = fde_pkg::fde_is_nan(scale);
        inf_x  = (x[30:0] == 31'h7F80_0000);
        inf_m  = (scale[30:0] == 31'h7F80_0000);
        zero_x = (x[30:0] == 31'd0);
        zero_m = (scale[30:0] == 31'd0);
        psign  = x[31] ^ scale[31];
        spec1  = 1'b1;
        specv1 = fde_pkg::QNAN;
        if (nan_x || nan_m || (inf_x && zero_m) || (inf_m && zero_x))
            specv1 = fde_pkg::QNAN;
        else if (inf_x || inf_m)
            specv1 = {psign, 8'hFF, 23'd0};
        else if (zero_x || zero_m)
            specv1 = {psign, 31'd0};
        else
            spec1 = 1'b0;
    end

    always_comb
    begin
        l1 = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (s1_p_reg[i])
                l1 = 6'(i);
        end
        n1 = s1_p_reg << (6'd47 - l1);
    end

    always_comb
    begin
        // larger magnitude goes first
        if (s3_f_reg[30:0] < c3_reg[30:0])
        begin
            big = c3_reg;
            lit = s3_f_reg;
        end
        else
        begin
            big = s3_f_reg;
            lit = c3_reg;
        end
        eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        el   = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
        mb   = {(big[30:23] != 8'd0), big[22:0]};
        ml   = {(lit[30:23] != 8'd0), lit[22:0]};
        dexp = eb - el;
        dcl  = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
        lx   = {ml, 3'b000};
        lsh  = lx >> dcl;
        lost = |(lx & ~({27{1'b1}} << dcl));
        lal  = {lsh[26:1], lsh[0] | lost};
        sub  = big[31] ^ lit[31];
        sum  = sub ? ({1'b0, mb, 3'b000} - {1'b0, lal})
                   : ({1'b0, mb, 3'b000} + {1'b0, lal});
        spec4  = 1'b1;
        specv4 = fde_pkg::QNAN;
        if (fde_pkg::fde_is_nan(big) || fde_pkg::fde_is_nan(lit))
            specv4 = fde_pkg::QNAN;
        else if (big[30:0] == 31'h7F80_0000)
            specv4 = (sub && (lit[30:0] == 31'h7F80_0000)) ? fde_pkg::QNAN : big;
        else if (sum == 28'd0)
            specv4 = {(sub ? 1'b0 : big[31]), 31'd0};
        else
            spec4 = 1'b0;
    end

    always_comb
    begin
        l5 = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (s4_sum_reg[i])
                l5 = 5'(i);
        end
        n5 = s4_sum_reg << (5'd27 - l5);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg     <= mx * mm;
            s1_e_reg     <= $signed({3'b000, ex}) + $signed({3'b000, em}) - 11'sd173;
            s1_sign_reg  <= psign;
            s1_spec_reg  <= spec1;
            s1_specv_reg <= specv1;
            c1_reg       <= offset;

            s2_sig_reg   <= {n1[47:24], n1[23], |n1[22:0]};
            s2_e_reg     <= s1_e_reg + $signed({5'd0, l1});
            s2_sign_reg  <= s1_sign_reg;
            s2_spec_reg  <= s1_spec_reg;
            s2_specv_reg <= s1_specv_reg;
            c2_reg       <= c1_reg;

            s3_f_reg     <= s2_spec_reg ? s2_specv_reg
                            : fde_pkg::fde_round_pack(s2_sign_reg, s2_e_reg, s2_sig_reg);
            c3_reg       <= c2_reg;

            s4_sum_reg   <= sum;
            s4_e_reg     <= eb;
            s4_sign_reg  <= big[31];
            s4_spec_reg  <= spec4;
            s4_specv_reg <= specv4;

            s5_sig_reg   <= {n5[27:4], n5[3], |n5[2:0]};
            s5_e_reg     <= $signed({6'd0, l5}) + $signed({3'b000, s4_e_reg}) - 11'sd26;
            s5_sign_reg  <= s4_sign_reg;
            s5_spec_reg  <= s4_spec_reg;
            s5_specv_reg <= s4_specv_reg;

            s6_f_reg     <= s5_spec_reg ? s5_specv_reg
                            : fde_pkg::fde_round_pack(s5_sign_reg, s5_e_reg, s5_sig_reg);
            s7_u_reg     <= fde_pkg::fde_to_uint(s6_f_reg);
        end
    end

endmodule

// ===== hw/rtl/fde_back.sv =====
// ----------------------------------------------------------------------------
// fde_back: execution pipeline and output register
// Pulls items from the queue, scales strict fields, packs the code word.
// ----------------------------------------------------------------------------
module fde_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  fde_pkg::fde_item_t  head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata
);

    localparam int N = fde_pkg::SCALE_STAGES;

    logic [N-1:0]      valid_reg;
    fde_pkg::fde_meta_t meta_reg [N];
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [47:0]       out_data_reg;
    logic              adv;

    logic [31:0] st;
    logic [31:0] sb;
    logic [31:0] body;
    logic [32:0] mask;
    logic [32:0] masked;
    logic [34:0] code;
    logic [5:0]  len;
    fde_pkg::fde_meta_t last;

    // whole pipeline moves unless the output register is held
    assign adv      = !out_valid_reg || m_tready;
    assign pop      = adv && head_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    fde_scale u_scale_target
    (
        .clk    (clk),
        .en     (adv),
        .x      (head_item.target),
        .scale  (head_item.scale),
        .offset (head_item.offset),
        .result (st)
    );

    fde_scale u_scale_base
    (
        .clk    (clk),
        .en     (adv),
        .x      (head_item.base),
        .scale  (head_item.scale),
        .offset (head_item.offset),
        .result (sb)
    );

    always_comb
    begin
        last   = meta_reg[N-1];
        body   = last.strict ? (last.xor_en ? (sb ^ st) : st) : last.body;
        mask   = (33'd1 << last.body_len) - 33'd1;
        masked = {1'b0, body} & mask;
        code   = ({32'd0, last.pre_bits} << last.body_len) | {2'b00, masked};
        len    = {4'd0, last.pre_len} + last.body_len;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = valid_reg[N-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                valid_reg <= {valid_reg[N-2:0], pop};
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= head_item.meta;
            for (int i = 1; i < N; i++)
                meta_reg[i] <= meta_reg[i-1];
            out_data_reg <= {7'd0, len, code};
        end
    end

endmodule

// ===== hw/rtl/field_delta_encoder.sv =====
// ----------------------------------------------------------------------------
// field_delta_encoder: delta code generator for 32-bit state fields
// Encodes a field against its previous value into a code of 1 to 35 bits.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready/s_tdata, one field per item; codes
// leave on m_tvalid/m_tready/m_tdata, exactly one code per input item, in
// order. Users must write xor_enable (index 0) and zero_flag_enable (index 1)
// via cfg_we/cfg_addr/cfg_wdata only while no item is in flight; not enforced.
//
// Throughput is one item per cycle while m_tready stays high. From input
// acceptance to m_tvalid, an item passes the front register, a queue slot,
// the seven-stage float scale pipeline (multiply, normalize, round, add,
// normalize, round, truncate) and the output register. Every item passes
// the scale pipeline, so latency is the same for all field kinds.
//
// When m_tready is low the output register holds its code and the back
// pipeline freezes; the front keeps taking items until the queue fills, then
// s_tready drops. Reset clears both registers to 0 and empties all stages.
// ----------------------------------------------------------------------------
module field_delta_encoder
#(
    parameter int QDEPTH = fde_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // previous_word[31:0], current_word[63:32], field_kind[66:64],
    // field_width[72:67], range_limit[104:73], scale_factor[136:105],
    // scale_offset[168:137], zero fill above
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // code_word[34:0], code_length[40:35], zero fill above
    output logic [47:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [0:0]   cfg_wdata
);

    logic               xor_en_reg;
    logic               zero_en_reg;
    logic               front_valid;
    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               head_valid;
    fde_pkg::fde_item_t front_item;
    fde_pkg::fde_item_t head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_en_reg  <= 1'b0;
            zero_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fde_pkg::REG_XOR:  xor_en_reg  <= cfg_wdata[0];
                fde_pkg::REG_ZERO: zero_en_reg <= cfg_wdata[0];
                default:           xor_en_reg  <= xor_en_reg;
            endcase
        end
    end

    assign q_push = front_valid && !q_full;

    fde_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .xor_en     (xor_en_reg),
        .zero_en    (zero_en_reg),
        .q_full     (q_full),
        .item_valid (front_valid),
        .item       (front_item)
    );

    fde_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    fde_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[40:35] >= 6'd1) && (m_tdata[40:35] <= 6'd35))
        else $error("code length out of range");

    a_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[34:0] >> m_tdata[40:35]) == 35'd0))
        else $error("code bits above code length");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (front_valid && q_full))
        else $error("input stalled without a full queue");

endmodule

// ===== test/field_delta_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// field_delta_encoder_tb: self-checking bench for the field delta encoder
// Streams directed and random fields through the encoder under each register
// setting, predicts every code with a bit-accurate model of the encoding
// (including single-precision scaling) and compares codes in order.
// ----------------------------------------------------------------------------
module field_delta_encoder_tb;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [31:0] prev_word;
        logic [31:0] cur_word;
        logic [2:0]  kind;
        logic [5:0]  width;
        logic [31:0] limit;
        logic [31:0] scale;
        logic [31:0] offset;
    } field_t;

    typedef struct {
        logic [34:0] code;
        logic [5:0]  len;
    } code_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         cfg_we;
    logic [0:0]   cfg_addr;
    logic [0:0]   cfg_wdata;

    field_t pending_fields[$];
    code_t  expected_codes[$];
    field_t offered;
    logic   xor_on;
    logic   zero_on;
    int     errors;
    int     burst_left;
    int     gap_left;
    int     stall_left;
    int     hold_left;
    logic   hold_req;
    logic   hold_done;
    int     cycles;

    field_delta_encoder dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- float helpers ----------------
    function automatic logic sgl_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 0);
    endfunction

    function automatic logic sgl_inf(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 0);
    endfunction

    function automatic real sgl_to_real(input logic [31:0] f);
        logic [63:0] d;
        real r;
        if (f[30:23] == 8'hFF)
        begin
            d = {f[31], 11'h7FF, f[22:0], 29'd0};
            r = $bitstoreal(d);
        end
        else if (f[30:23] == 8'd0)
        begin
            r = $itor(f[22:0]) * (2.0 ** (-149));
            if (f[31])
                r = -r;
        end
        else
        begin
            d = {f[31], 11'(f[30:23] - 127 + 1023), f[22:0], 29'd0};
            r = $bitstoreal(d);
        end
        return r;
    endfunction

    // round a double to single, nearest even, with subnormals and overflow
    function automatic logic [31:0] real_to_sgl(input real r);
        logic [63:0] d;
        logic [63:0] mm;
        logic [63:0] q;
        logic        guard;
        logic        sticky;
        int          be;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? fde_pkg::QNAN : {d[63], 8'hFF, 23'd0};
        if (d[62:0] == 0)
            return {d[63], 31'd0};
        mm = {11'd0, 1'b1, d[51:0]};
        be = int'(d[62:52]) - 1023 + 127;
        sh = (be >= 1) ? 29 : 29 + 1 - be;
        if (sh > 60)
            return {d[63], 31'd0};
        q      = mm >> sh;
        guard  = mm[sh-1];
        sticky = |(mm & ((64'd1 << (sh - 1)) - 1));
        q      = q + (guard & (sticky | q[0]));
        if (be >= 1)
        begin
            if (q[24])
            begin
                q  = q >> 1;
                be = be + 1;
            end
            if (be >= 255)
                return {d[63], 8'hFF, 23'd0};
            return {d[63], 8'(be), q[22:0]};
        end
        return {d[63], q[30:0]};
    endfunction

    function automatic logic [31:0] sgl_to_uint(input logic [31:0] f);
        logic [31:0] m;
        m = {8'd0, 1'b1, f[22:0]};
        if (sgl_nan(f) || f[31])
            return 32'd0;
        if (f[30:23] >= 8'd159)
            return 32'hFFFF_FFFF;
        if (f[30:23] < 8'd127)
            return 32'd0;
        if (f[30:23] >= 8'd150)
            return m << (f[30:23] - 8'd150);
        return m >> (8'd150 - f[30:23]);
    endfunction

    function automatic logic [31:0] scale_field(input logic [31:0] w, input logic [31:0] m,
                                                input logic [31:0] c);
        logic [31:0] p;
        logic [31:0] s;
        if (sgl_nan(w) || sgl_nan(m) || sgl_nan(c))
            return 32'd0;
        if ((sgl_inf(w) && m[30:0] == 0) || (sgl_inf(m) && w[30:0] == 0))
            return 32'd0;
        p = real_to_sgl(sgl_to_real(w) * sgl_to_real(m));
        if (sgl_inf(p) && sgl_inf(c) && (p[31] != c[31]))
            return 32'd0;
        s = real_to_sgl(sgl_to_real(p) + sgl_to_real(c));
        return sgl_to_uint(s);
    endfunction

    // ---------------- code prediction ----------------
    function automatic void append_bits(inout logic [63:0] acc, inout int n,
                                        input logic [31:0] v, input int w);
        if (w == 0)
            return;
        acc = (acc << w) | (64'(v) & ((64'd1 << w) - 1));
        n   = n + w;
    endfunction

    function automatic code_t encode_field(input field_t f, input logic x_en,
                                           input logic z_en);
        logic [63:0] acc;
        int          n;
        int          w;
        logic [31:0] b;
        logic [31:0] t;
        real         ft;
        real         lim;
        logic        full;
        int          it;
        code_t       r;
        acc = 0;
        n   = 0;
        w   = (f.width > 32) ? 32 : int'(f.width);
        b   = f.prev_word;
        t   = f.cur_word;
        if (b == t)
            append_bits(acc, n, 1, 1);
        else
        begin
            append_bits(acc, n, 0, 1);
            if (z_en && t == 0)
                append_bits(acc, n, 1, 1);
            else
            begin
                if (z_en)
                    append_bits(acc, n, 0, 1);
                if (f.kind == fde_pkg::KIND_RANGED)
                begin
                    full = 1'b1;
                    it   = 0;
                    if (!sgl_nan(t))
                    begin
                        ft = sgl_to_real(t);
                        if (ft >= -2147483648.0 && ft < 2147483648.0)
                        begin
                            it   = $rtoi(ft);
                            full = ($itor(it) != ft);
                            if (!sgl_nan(f.limit))
                            begin
                                lim  = sgl_to_real(f.limit);
                                full = full || (ft > lim) || (ft < -lim);
                            end
                        end
                    end
                    if (full)
                    begin
                        append_bits(acc, n, 1, 1);
                        append_bits(acc, n, x_en ? (b ^ t) : t, 32);
                    end
                    else
                    begin
                        append_bits(acc, n, 0, 1);
                        append_bits(acc, n, it, w);
                    end
                end
                else if (f.kind >= fde_pkg::KIND_UNSIGNED && f.kind <= fde_pkg::KIND_STRICT)
                begin
                    if (f.kind == fde_pkg::KIND_STRICT)
                    begin
                        t = scale_field(t, f.scale, f.offset);
                        b = scale_field(b, f.scale, f.offset);
                    end
                    append_bits(acc, n, x_en ? (b ^ t) : t, w);
                end
            end
        end
        r.code = acc[34:0];
        r.len  = 6'(n);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        case ($urandom_range(0, 9))
            0, 1: f = $urandom;
            2, 3: f = real_to_sgl($itor($urandom_range(0, 2000)) - 1000.0);
            4:    f = real_to_sgl($itor($signed($urandom)));
            5:    f = real_to_sgl(($itor($urandom_range(0, 2000)) - 1000.0) / 4.0);
            6:    f = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
            7:    f = {$urandom_range(0, 1) == 1, 31'd0};
            8:    f = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
            default: f = real_to_sgl($itor($urandom_range(0, 70000)));
        endcase
        return f;
    endfunction

    function automatic field_t rand_field();
        field_t f;
        f.kind   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                   : (($urandom_range(0, 19) == 0) ? KIND_NONE
                   : 3'($urandom_range(1, 4)));
        f.width  = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
        f.limit  = rand_float();
        f.scale  = rand_float();
        f.offset = rand_float();
        if (f.kind == fde_pkg::KIND_RANGED || f.kind == fde_pkg::KIND_STRICT)
        begin
            f.prev_word = rand_float();
            f.cur_word  = rand_float();
        end
        else
        begin
            f.prev_word = $urandom;
            f.cur_word  = $urandom;
        end
        case ($urandom_range(0, 9))
            0: f.cur_word = f.prev_word;
            1: f.cur_word = 32'd0;
            default: ;
        endcase
        return f;
    endfunction

    function automatic field_t make_field(input logic [31:0] p, input logic [31:0] c,
                                          input logic [2:0] k, input logic [5:0] w,
                                          input logic [31:0] l, input logic [31:0] m,
                                          input logic [31:0] o);
        field_t f;
        f.prev_word = p;
        f.cur_word  = c;
        f.kind      = k;
        f.width     = w;
        f.limit     = l;
        f.scale     = m;
        f.offset    = o;
        return f;
    endfunction

    task automatic queue_directed();
        logic [31:0] one;
        logic [31:0] big;
        one = 32'h3F80_0000;
        big = 32'h4F00_0000;
        pending_fields.push_back(make_field(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                            fde_pkg::KIND_UNSIGNED, 6'd32, 0, 0, 0));
        pending_fields.push_back(make_field(0, 32'hFFFF_FFFF, fde_pkg::KIND_UNSIGNED, 6'd32,
                                            0, 0, 0));
        pending_fields.push_back(make_field(32'hFFFF_FFFF, 0, fde_pkg::KIND_SIGNED, 6'd63,
                                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_fields.push_back(make_field(5, 32'hA5A5_5A5A, fde_pkg::KIND_SIGNED, 6'd0,
                                            0, 0, 0));
        pending_fields.push_back(make_field(5, 32'h1234_5677, fde_pkg::KIND_UNSIGNED, 6'd1,
                                            0, 0, 0));
        pending_fields.push_back(make_field(1, 2, KIND_NONE, 6'd32, 0, 0, 0));
        pending_fields.push_back(make_field(1, 2, 3'd5, 6'd32, 0, 0, 0));
        pending_fields.push_back(make_field(1, 2, 3'd7, 6'd32, 0, 0, 0));
        // ranged: in-range integer, out of range, fraction, NaN limit, int32 edge
        pending_fields.push_back(make_field(0, 32'hC2C8_0000, fde_pkg::KIND_RANGED, 6'd12,
                                            32'h42C8_0000, 0, 0));
        pending_fields.push_back(make_field(0, 32'h42CA_0000, fde_pkg::KIND_RANGED, 6'd12,
                                            32'h42C8_0000, 0, 0));
        pending_fields.push_back(make_field(0, 32'h3F00_0000, fde_pkg::KIND_RANGED, 6'd8,
                                            big, 0, 0));
        pending_fields.push_back(make_field(0, 32'h4120_0000, fde_pkg::KIND_RANGED, 6'd8,
                                            fde_pkg::QNAN, 0, 0));
        pending_fields.push_back(make_field(0, fde_pkg::NEG_2P31, fde_pkg::KIND_RANGED, 6'd32,
                                            32'h7F80_0000, 0, 0));
        pending_fields.push_back(make_field(0, big, fde_pkg::KIND_RANGED, 6'd32,
                                            32'h7F80_0000, 0, 0));
        pending_fields.push_back(make_field(0, fde_pkg::QNAN, fde_pkg::KIND_RANGED, 6'd32,
                                            big, 0, 0));
        // strict: plain, NaN scale, negative, fraction below zero, saturation
        pending_fields.push_back(make_field(32'h4120_0000, 32'h4148_0000, fde_pkg::KIND_STRICT,
                                            6'd16, 0, 32'h4000_0000, one));
        pending_fields.push_back(make_field(one, 32'h4000_0000, fde_pkg::KIND_STRICT, 6'd32, 0,
                                            fde_pkg::QNAN, 0));
        pending_fields.push_back(make_field(one, 32'hC000_0000, fde_pkg::KIND_STRICT, 6'd32, 0,
                                            one, 0));
        pending_fields.push_back(make_field(one, 32'hBF00_0000, fde_pkg::KIND_STRICT, 6'd32, 0,
                                            one, 0));
        pending_fields.push_back(make_field(one, 32'h5F80_0000, fde_pkg::KIND_STRICT, 6'd32, 0,
                                            one, 0));
        pending_fields.push_back(make_field(32'h7F80_0000, 32'h4F80_0000, fde_pkg::KIND_STRICT,
                                            6'd40, 0, 0, 32'hFF80_0000));
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == fde_pkg::REG_XOR)
            xor_on = val;
        else
            zero_on = val;
    endtask

    // sample on the falling edge so that all edge updates have settled
    task automatic wait_idle();
        while (pending_fields.size() != 0 || s_tvalid || expected_codes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------- sender ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_codes.push_back(encode_field(offered, xor_on, zero_on));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_fields.size() != 0)
                begin
                    offered = pending_fields.pop_front();
                    s_tdata <= {7'd0, offered.offset, offered.scale, offered.limit,
                                offered.width, offered.kind, offered.cur_word,
                                offered.prev_word};
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            // long hold-off so the encoder fills and drops s_tready
            if (hold_left == 0)
                hold_left = 300;
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
            if (hold_left == 0)
                hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 6);
        end
    end

    // ---------------- checker ----------------
    always @(posedge clk)
    begin
        code_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_codes.size() == 0)
            begin
                $error("unexpected code %h", m_tdata);
                errors = errors + 1;
            end
            else
            begin
                want = expected_codes.pop_front();
                if (m_tdata[34:0] !== want.code)
                begin
                    $error("code_word expected %h actual %h", want.code, m_tdata[34:0]);
                    errors = errors + 1;
                end
                if (m_tdata[40:35] !== want.len)
                begin
                    $error("code_length expected %0d actual %0d", want.len, m_tdata[40:35]);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        errors    = 0;
        cycles    = 0;
        xor_on    = 1'b0;
        zero_on   = 1'b0;
        hold_req  = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = fde_pkg::REG_XOR;
        cfg_wdata = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(fde_pkg::REG_XOR, phase[0]);
            write_reg(fde_pkg::REG_ZERO, phase[1]);
            queue_directed();
            for (int i = 0; i < 180; i++)
                pending_fields.push_back(rand_field());
            if (phase == 3)
            begin
                while (pending_fields.size() > 150)
                    @(posedge clk);
                hold_req = 1'b1;
            end
            wait_idle();
        end
        write_reg(fde_pkg::REG_XOR, 1'b0);
        write_reg(fde_pkg::REG_ZERO, 1'b0);
        for (int i = 0; i < 60; i++)
            pending_fields.push_back(rand_field());
        wait_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
